// ----- hdl/fud_pkg.sv -----
package fud_pkg;

    // Default depth of the job queue between front and back
    localparam int FUD_QUEUE_DEPTH = 4;

    // Results one input byte can cause at most
    localparam int FUD_SLOTS = 4;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        ESC_IDLE = 2'd0,
        ESC_PCT  = 2'd1,
        ESC_HEX1 = 2'd2
    } t_esc;

    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       in_value;
        logic       field_end;
        logic       body_end;
    } t_result;

    typedef struct packed {
        logic [2:0]                count;
        t_result [FUD_SLOTS-1:0]   slot;
    } t_job;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] nib;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.is_hex = 1'b1;
            h.nib    = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            h.is_hex = 1'b1;
            h.nib    = c[3:0] + 4'd9;
        end
        return h;
    endfunction

    function automatic t_result mk_result(input logic [7:0] data, input logic byte_valid,
                                          input logic in_value, input logic field_end,
                                          input logic body_end);
        t_result r;
        r.data       = byte_valid ? data : 8'h00;
        r.byte_valid = byte_valid;
        r.in_value   = in_value;
        r.field_end  = field_end;
        r.body_end   = body_end;
        return r;
    endfunction

endpackage

// ----- hdl/fud_front.sv -----
module fud_front
    import fud_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_job_push,
    output t_job       o_job
);

    t_esc       r_esc, n_esc;
    logic       r_value_phase, n_value_phase;
    logic [7:0] r_held, n_held;

    t_esc       s_esc_mid;
    logic       s_phase_mid;
    logic [7:0] s_held_mid;
    logic       s_run;
    logic       s_accept;
    t_hex       s_hex;
    t_hex       s_held_hex;
    t_job       s_job;

    assign s_accept   = i_push && !i_full;
    assign s_hex      = hex_decode(i_in_byte);
    assign s_held_hex = hex_decode(r_held);

    // Next state: escape stage, key/value phase and held digit
    always_comb begin
        s_esc_mid   = r_esc;
        s_phase_mid = r_value_phase;
        s_held_mid  = r_held;
        s_run       = 1'b0;
        unique case (r_esc)
            ESC_PCT: begin
                if (s_hex.is_hex) begin
                    s_esc_mid  = ESC_HEX1;
                    s_held_mid = i_in_byte;
                end else begin
                    s_run = 1'b1;
                end
            end
            ESC_HEX1: begin
                s_esc_mid  = ESC_IDLE;
                s_held_mid = 8'h00;
                s_run      = !s_hex.is_hex;
            end
            default: begin
                s_run = 1'b1;
            end
        endcase
        if (s_run) begin
            s_esc_mid = ESC_IDLE;
            if (i_in_byte == CH_AMP) begin
                s_phase_mid = 1'b0;
            end else if (i_in_byte == CH_EQ && !r_value_phase) begin
                s_phase_mid = 1'b1;
            end else if (i_in_byte == CH_PCT) begin
                s_esc_mid = ESC_PCT;
            end
        end
        if (!s_accept) begin
            n_esc         = r_esc;
            n_value_phase = r_value_phase;
            n_held        = r_held;
        end else if (i_in_last) begin
            n_esc         = ESC_IDLE;
            n_value_phase = 1'b0;
            n_held        = 8'h00;
        end else begin
            n_esc         = s_esc_mid;
            n_value_phase = s_phase_mid;
            n_held        = s_held_mid;
        end
    end

    // Outputs: gather every result of this byte into one job
    always_comb begin
        logic [2:0] k;
        s_job = '0;
        k     = 3'd0;
        unique case (r_esc)
            ESC_PCT: begin
                if (!s_hex.is_hex) begin
                    s_job.slot[k[1:0]] = mk_result(CH_PCT, 1'b1, r_value_phase, 1'b0, 1'b0);
                    k = k + 3'd1;
                end
            end
            ESC_HEX1: begin
                if (s_hex.is_hex) begin
                    s_job.slot[k[1:0]] = mk_result({s_held_hex.nib, s_hex.nib}, 1'b1,
                                                   r_value_phase, 1'b0, 1'b0);
                    k = k + 3'd1;
                end else begin
                    s_job.slot[k[1:0]] = mk_result(CH_PCT, 1'b1, r_value_phase, 1'b0, 1'b0);
                    k = k + 3'd1;
                    s_job.slot[k[1:0]] = mk_result(r_held, 1'b1, r_value_phase, 1'b0, 1'b0);
                    k = k + 3'd1;
                end
            end
            default: begin
            end
        endcase
        if (s_run) begin
            if (i_in_byte == CH_AMP) begin
                s_job.slot[k[1:0]] = mk_result(8'h00, 1'b0, r_value_phase, 1'b1, 1'b0);
                k = k + 3'd1;
            end else if ((i_in_byte == CH_EQ && !r_value_phase) || i_in_byte == CH_PCT) begin
                k = k;
            end else if (i_in_byte == CH_PLUS) begin
                s_job.slot[k[1:0]] = mk_result(CH_SPACE, 1'b1, r_value_phase, 1'b0, 1'b0);
                k = k + 3'd1;
            end else begin
                s_job.slot[k[1:0]] = mk_result(i_in_byte, 1'b1, r_value_phase, 1'b0, 1'b0);
                k = k + 3'd1;
            end
        end
        if (i_in_last) begin
            // Flush an escape cut short by the body end
            if (s_esc_mid == ESC_PCT || s_esc_mid == ESC_HEX1) begin
                s_job.slot[k[1:0]] = mk_result(CH_PCT, 1'b1, s_phase_mid, 1'b0, 1'b0);
                k = k + 3'd1;
            end
            if (s_esc_mid == ESC_HEX1) begin
                s_job.slot[k[1:0]] = mk_result(s_held_mid, 1'b1, s_phase_mid, 1'b0, 1'b0);
                k = k + 3'd1;
            end
            s_job.slot[k[1:0]] = mk_result(8'h00, 1'b0, s_phase_mid, 1'b1, 1'b1);
            k = k + 3'd1;
        end
        s_job.count = k;
    end

    assign o_job      = s_job;
    assign o_job_push = s_accept && (s_job.count != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc         <= ESC_IDLE;
            r_value_phase <= 1'b0;
            r_held        <= 8'h00;
        end else begin
            r_esc         <= n_esc;
            r_value_phase <= n_value_phase;
            r_held        <= n_held;
        end
    end

    a_held_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc != ESC_HEX1 |-> r_held == 8'h00)
        else $error("held digit not cleared outside escape");

    a_held_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc == ESC_HEX1 |-> s_held_hex.is_hex)
        else $error("held digit is not a hex digit");

endmodule

// ----- hdl/fud_queue.sv -----
module fud_queue
    import fud_pkg::*;
#(
    parameter int DEPTH = FUD_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_wr_job,
    output logic o_full,
    input  logic i_rd,
    output logic o_valid,
    output t_job o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             s_wr;
    logic             s_rd;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign s_wr    = i_wr && !o_full;
    assign s_rd    = i_rd && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (s_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (s_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (s_wr && !s_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (s_rd && !s_wr) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_wr) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("job queue count overflow");

endmodule

// ----- hdl/fud_emit.sv -----
module fud_emit
    import fud_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_job_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_in_value,
    output logic       o_field_end,
    output logic       o_body_end,
    output logic       o_last
);

    t_result    r_out;
    logic       r_out_last;
    logic       r_out_valid, n_out_valid;
    logic [1:0] r_idx, n_idx;
    logic       s_load;
    logic       s_slot_last;

    // Load the output register whenever it is free or being drained
    assign s_load      = i_job_valid && (!r_out_valid || i_pop);
    assign s_slot_last = ({1'b0, r_idx} + 3'd1) == i_job.count;
    assign o_job_pop   = s_load && s_slot_last;

    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (s_load) begin
            n_idx       = s_slot_last ? 2'd0 : r_idx + 2'd1;
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_out      <= i_job.slot[r_idx];
            r_out_last <= s_slot_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else begin
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_out_byte   = r_out.data;
    assign o_byte_valid = r_out.byte_valid;
    assign o_in_value   = r_out.in_value;
    assign o_field_end  = r_out.field_end;
    assign o_body_end   = r_out.body_end;
    assign o_last       = r_out_last;

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_job_valid |-> r_idx == 2'd0)
        else $error("slot index left mid-job with no job queued");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid |-> ({1'b0, r_idx} < i_job.count))
        else $error("slot index beyond job result count");

endmodule

// ----- hdl/form_urlencoded_decoder.sv -----
// Channel   Direction  Handshake               Payload
// input     in         push / full             i_in_byte, i_in_last
// result    out        empty / pop             o_out_byte, o_byte_valid, o_in_value,
//                                              o_field_end, o_body_end, o_last
//
// A byte is taken at every edge while full is low; the front queues all of its results as
// one job in the cycle of the transaction, and the back loads one result per cycle into the
// output register while that is empty or popped; results reach the ports from the job queue
// through that register. A byte causes up to four results, emitted one by one; a '%', a
// first escape digit or splitting '=' not last causes none; full rises only on a full queue.
// Reset is synchronous, active low, clears decode state, queue and output register.
module form_urlencoded_decoder
    import fud_pkg::*;
#(
    parameter int QUEUE_DEPTH = FUD_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input transactions: raw body bytes
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    // result transactions: decoded bytes and markers
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_in_value,
    output logic       o_field_end,
    output logic       o_body_end,
    output logic       o_last
);

    // Front -> queue: one job per byte that causes any result
    logic s_job_push;
    t_job s_job_in;

    // Queue -> back: oldest job not yet fully emitted
    logic s_job_valid;
    t_job s_job_head;
    logic s_job_pop;

    // Classify each byte, track key/value phase and pending escape
    fud_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_full     (full),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_job_push (s_job_push),
        .o_job      (s_job_in)
    );

    // Decouple front and back so either can stall alone
    fud_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (s_job_push),
        .i_wr_job (s_job_in),
        .o_full   (full),
        .i_rd     (s_job_pop),
        .o_valid  (s_job_valid),
        .o_head   (s_job_head)
    );

    // Serialize each job into single results, one per cycle while the result port is not stalled
    fud_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (s_job_valid),
        .i_job        (s_job_head),
        .o_job_pop    (s_job_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_in_value   (o_in_value),
        .o_field_end  (o_field_end),
        .o_body_end   (o_body_end),
        .o_last       (o_last)
    );

endmodule

// ----- bench/form_urlencoded_decoder_tb.sv -----
module form_urlencoded_decoder_tb;
    import fud_pkg::*;

    // Raw body byte waiting to be offered; drain holds it back until every
    // decoded result of earlier bytes has been taken.
    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       drain;
    } t_raw_byte;

    // One decoded result as it should appear on the result ports.
    typedef struct {
        logic [7:0] data;
        logic       byte_valid;
        logic       in_value;
        logic       field_end;
        logic       body_end;
        logic       last;
    } t_decoded;

    localparam int IDLE_LIMIT  = 4000;   // cycles without any transaction
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int TAIL_CYCLES = 30;     // settle time after the last result
    localparam int BODY_ITEMS  = 430;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       push      = 1'b0;
    logic       pop       = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_in_last = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_in_value;
    logic       o_field_end;
    logic       o_body_end;
    logic       o_last;

    form_urlencoded_decoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_in_value   (o_in_value),
        .o_field_end  (o_field_end),
        .o_body_end   (o_body_end),
        .o_last       (o_last)
    );

    always #1 i_clk = ~i_clk;

    t_raw_byte  pending_bytes[$];    // bytes not yet offered to the block
    t_decoded   awaited_results[$];  // predicted results, oldest first
    t_decoded   step_out[$];         // results of the byte being decoded
    logic [7:0] draft[$];            // body under construction

    // Decoder state mirrored on the bench side
    logic       dec_in_value = 1'b0;
    t_esc       dec_esc      = ESC_IDLE;
    logic [7:0] dec_held     = 8'h00;

    bit in_fire  = 1'b0;
    bit out_fire = 1'b0;
    int in_count    = 0;
    int idle_cycles = 0;
    int failures    = 0;
    int tx_gap = 0, tx_burst = 0;
    int rx_gap = 0, rx_burst = 0;
    int hold_left = 0, hold_at = 40;

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------

    // {is_hex, nibble} of an ASCII hex digit of either case
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
        if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
        if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
        return 5'd0;
    endfunction

    // Tag a result with the current key/value phase and stage it.
    task automatic emit(input logic [7:0] data, input logic valid, input logic fe,
                        input logic be);
        t_decoded r;
        r.data       = valid ? data : 8'h00;
        r.byte_valid = valid;
        r.in_value   = dec_in_value;
        r.field_end  = fe;
        r.body_end   = be;
        r.last       = 1'b0;
        step_out.push_back(r);
    endtask

    // Handle a byte with no escape pending.
    task automatic plain_byte(input logic [7:0] b);
        if (b == CH_AMP) begin
            emit(8'h00, 1'b0, 1'b1, 1'b0);
            dec_in_value = 1'b0;
        end else if (b == CH_EQ && !dec_in_value) begin
            dec_in_value = 1'b1;
        end else if (b == CH_PCT) begin
            dec_esc = ESC_PCT;
        end else if (b == CH_PLUS) begin
            emit(CH_SPACE, 1'b1, 1'b0, 1'b0);
        end else begin
            emit(b, 1'b1, 1'b0, 1'b0);
        end
    endtask

    // Advance the mirrored decoder by one accepted byte and queue its results.
    task automatic decode_byte(input logic [7:0] b, input logic fin);
        logic [4:0] h;
        logic [4:0] hi;
        h = hex_nibble(b);
        step_out.delete();
        case (dec_esc)
            ESC_PCT: begin
                if (h[4]) begin
                    dec_held = b;
                    dec_esc  = ESC_HEX1;
                end else begin
                    // failed escape: emit '%' and reprocess the byte
                    emit(CH_PCT, 1'b1, 1'b0, 1'b0);
                    dec_esc = ESC_IDLE;
                    plain_byte(b);
                end
            end
            ESC_HEX1: begin
                if (h[4]) begin
                    hi = hex_nibble(dec_held);
                    emit({hi[3:0], h[3:0]}, 1'b1, 1'b0, 1'b0);
                end else begin
                    emit(CH_PCT, 1'b1, 1'b0, 1'b0);
                    emit(dec_held, 1'b1, 1'b0, 1'b0);
                end
                dec_esc  = ESC_IDLE;
                dec_held = 8'h00;
                if (!h[4]) plain_byte(b);
            end
            default: begin
                plain_byte(b);
            end
        endcase
        if (fin) begin
            // flush an escape cut short by the body end, then close the body
            if (dec_esc == ESC_PCT) begin
                emit(CH_PCT, 1'b1, 1'b0, 1'b0);
            end else if (dec_esc == ESC_HEX1) begin
                emit(CH_PCT, 1'b1, 1'b0, 1'b0);
                emit(dec_held, 1'b1, 1'b0, 1'b0);
            end
            emit(8'h00, 1'b0, 1'b1, 1'b1);
            dec_in_value = 1'b0;
            dec_esc      = ESC_IDLE;
            dec_held     = 8'h00;
        end
        if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i]) awaited_results.push_back(step_out[i]);
    endtask

    // Compare one taken result with the oldest prediction.
    task automatic check_result();
        t_decoded e;
        if (awaited_results.size() == 0) begin
            $error("unexpected result: out_byte %0h byte_valid %0b field_end %0b body_end %0b",
                   o_out_byte, o_byte_valid, o_field_end, o_body_end);
            failures++;
        end else begin
            e = awaited_results.pop_front();
            if (o_out_byte !== e.data) begin
                $error("out_byte: expected %0h, got %0h", e.data, o_out_byte);
                failures++;
            end
            if (o_byte_valid !== e.byte_valid) begin
                $error("byte_valid: expected %0b, got %0b", e.byte_valid, o_byte_valid);
                failures++;
            end
            if (o_in_value !== e.in_value) begin
                $error("in_value: expected %0b, got %0b", e.in_value, o_in_value);
                failures++;
            end
            if (o_field_end !== e.field_end) begin
                $error("field_end: expected %0b, got %0b", e.field_end, o_field_end);
                failures++;
            end
            if (o_body_end !== e.body_end) begin
                $error("body_end: expected %0b, got %0b", e.body_end, o_body_end);
                failures++;
            end
            if (o_last !== e.last) begin
                $error("last: expected %0b, got %0b", e.last, o_last);
                failures++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------

    // Mostly short gaps, a few long ones, and now and then a run with none.
    task automatic draw_gap(inout int burst, output int gap);
        int r;
        if (burst > 0) begin
            burst--;
            gap = 0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 55)      gap = 0;
            else if (r < 85) gap = $urandom_range(1, 3);
            else if (r < 97) gap = $urandom_range(4, 12);
            else             gap = $urandom_range(20, 80);
            if ($urandom_range(0, 29) == 0) burst = $urandom_range(16, 64);
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return 8'("0" + nib);
        return 8'(($urandom_range(0, 1) ? "A" : "a") + nib - 4'd10);
    endfunction

    task automatic draft_text(input string s);
        for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
    endtask

    // Move the drafted body to the sender, last byte flagged.
    task automatic send_draft(input logic drain);
        t_raw_byte rb;
        foreach (draft[i]) begin
            rb.data  = draft[i];
            rb.last  = (i == draft.size() - 1);
            rb.drain = drain && (i == 0);
            pending_bytes.push_back(rb);
        end
        draft.delete();
    endtask

    // One token of a key or value: plain text, '+', a good or broken escape,
    // a stray '=' or a raw byte of any value.
    task automatic draft_token();
        int         r;
        logic [7:0] v;
        r = $urandom_range(0, 99);
        v = 8'($urandom_range(0, 255));
        if (r < 40) begin
            draft.push_back(8'($urandom_range(0, 1) ? $urandom_range(97, 122)
                                                     : $urandom_range(48, 57)));
        end else if (r < 50) begin
            draft.push_back(CH_PLUS);
        end else if (r < 70) begin
            draft.push_back(CH_PCT);
            draft.push_back(hex_char(v[7:4]));
            draft.push_back(hex_char(v[3:0]));
        end else if (r < 78) begin
            draft.push_back(CH_PCT);
            if ($urandom_range(0, 1)) draft.push_back(hex_char(v[3:0]));
            case ($urandom_range(0, 5))
                0: draft.push_back(CH_AMP);
                1: draft.push_back(CH_EQ);
                2: draft.push_back(CH_PLUS);
                3: draft.push_back(CH_PCT);
                4: draft.push_back("g");
                default: draft.push_back(CH_SPACE);
            endcase
        end else if (r < 85) begin
            draft.push_back(CH_EQ);
        end else begin
            draft.push_back(v);
        end
    endtask

    // Well-formed fields with random content; a trailing '&' now and then.
    task automatic draft_body();
        int nfields;
        int ntok;
        nfields = $urandom_range(1, 4);
        for (int f = 0; f < nfields; f++) begin
            if (f > 0) draft.push_back(CH_AMP);
            ntok = $urandom_range(0, 5);
            repeat (ntok) draft_token();
            if ($urandom_range(0, 99) < 85) begin
                draft.push_back(CH_EQ);
                ntok = $urandom_range(0, 6);
                repeat (ntok) draft_token();
            end
        end
        if ($urandom_range(0, 9) == 0) draft.push_back(CH_AMP);
        if (draft.size() == 0) draft.push_back("x");
    endtask

    // ------------------------------------------------------------------
    // Sampling at the rising edge: predict accepted bytes, check results
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_fire  = 1'b0;
        out_fire = 1'b0;
        if (i_rst_n) begin
            if (push && !full) begin
                in_fire = 1'b1;
                decode_byte(i_in_byte, i_in_last);
                in_count++;
            end
            if (pop && !empty) begin
                out_fire = 1'b1;
                check_result();
            end
            if (in_fire || out_fire) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("form_urlencoded_decoder_tb failed");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Byte driver: change inputs at the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (in_fire) draw_gap(tx_burst, tx_gap);
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (push && !in_fire) begin
            // hold the offered byte until the block takes it
        end else if (tx_gap > 0) begin
            tx_gap--;
            push <= 1'b0;
        end else if (pending_bytes.size() == 0 ||
                     (pending_bytes[0].drain && awaited_results.size() != 0)) begin
            // pause: nothing left, or wait for the block to drain completely
            push <= 1'b0;
        end else begin
            i_in_byte <= pending_bytes[0].data;
            i_in_last <= pending_bytes[0].last;
            push      <= 1'b1;
            void'(pending_bytes.pop_front());
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random pops, plus long hold-offs to fill the block
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (out_fire) draw_gap(rx_burst, rx_gap);
        if (i_rst_n && in_count >= hold_at) begin
            hold_left = HOLD_CYCLES;
            hold_at  += 260;
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        // Escapes of both cases, a decoded '=' in a key, a held digit cut
        // short by '&', and a trailing '&' on the final byte.
        draft_text("%3D=%2a%2&");
        send_draft(1'b0);
        // Zero and all-ones bytes as data, '%' after '%', failed escapes
        // before '=' and '+', and an escape cut short by the body end.
        draft.push_back(8'h00);
        draft_text("%%=%a+");
        draft.push_back(8'hFF);
        draft_text("%F");
        send_draft(1'b0);
        // Held digit at a splitting '=', '%' before '&', lone '%' at the end.
        draft_text("%1=%&%");
        send_draft(1'b0);
        // Random bodies; the first one waits for the block to drain.
        draft_body();
        send_draft(1'b1);
        while (pending_bytes.size() < BODY_ITEMS) begin
            draft_body();
            send_draft($urandom_range(0, 19) == 0);
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || push) @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("form_urlencoded_decoder_tb passed");
        end else begin
            $display("form_urlencoded_decoder_tb failed");
        end
        $finish;
    end

endmodule
